// File: rtl/core/sphere_distance_field_splat_macros.svh
// assertion macros for the distance field splatter checker
// expects signals named clock and reset in the scope of use
`ifndef SPHERE_DISTANCE_FIELD_SPLAT_MACROS_SVH
`define SPHERE_DISTANCE_FIELD_SPLAT_MACROS_SVH

// checked only outside reset
`define SDFS_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("sdfs: port check failed");

// checked at every edge, reset included
`define SDFS_ASSERT_ALWAYS(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("sdfs: port check failed");

`endif

// File: rtl/core/sdfs_pkg.sv
// shared types and constants of the distance field splatter
// no dependencies
`timescale 1ns / 1ps

package sdfs_pkg;

   localparam int GRID_RES_DEF = 64;

   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_SPLAT = 2'd0;
   localparam cmd_type CMD_READ  = 2'd1;
   localparam cmd_type CMD_CLEAR = 2'd2;

   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_ORIGIN_X     = 3'd0;
   localparam csr_index_type CSR_ORIGIN_Y     = 3'd1;
   localparam csr_index_type CSR_ORIGIN_Z     = 3'd2;
   localparam csr_index_type CSR_VOXEL_STEP   = 3'd3;
   localparam csr_index_type CSR_INVERSE_STEP = 3'd4;

   // untouched voxel, also the saturation value
   localparam logic signed [31:0] FAR_VALUE = 32'sh7FFF_FFFF;

   localparam logic [30:0] STEP_RESET = 31'd65536;

endpackage

// File: rtl/core/sphere_distance_field_splat.sv
// sphere union distance field splatter, top level
// depends on sdfs_pkg
`timescale 1ns / 1ps

// splat: the bounding box one axis at a time, then each voxel in the box in turn
//   (through the shared multiplier, the bit-serial root unit, then an update),
//   then a closing state
// read: result registered once the output register is free; clear: sweeps the whole grid
// one word at a time; req_ready is high only while idle
// reset: registers back to defaults, then a sweep over the grid writes
//   the far value to every voxel, no word is taken until it ends
module sphere_distance_field_splat #(
   parameter int GRID_RES = sdfs_pkg::GRID_RES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  sdfs_pkg::cmd_type             req_command,
   input  logic signed [31:0]            req_center_x,
   input  logic signed [31:0]            req_center_y,
   input  logic signed [31:0]            req_center_z,
   input  logic [30:0]                   req_sphere_radius,
   input  logic [17:0]                   req_voxel_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [31:0]            rsp_distance_value,
   input  logic                          csr_write_enable,
   input  sdfs_pkg::csr_index_type       csr_index,
   input  logic [31:0]                   csr_wdata
);
   import sdfs_pkg::*;

   localparam int IDX_W  = $clog2(GRID_RES);
   localparam int CELLS  = GRID_RES * GRID_RES * GRID_RES;
   localparam int ADDR_W = $clog2(CELLS);
   localparam logic [ADDR_W-1:0] PLANE     = ADDR_W'(GRID_RES * GRID_RES);
   localparam logic [ADDR_W-1:0] ROW       = ADDR_W'(GRID_RES);
   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
   localparam logic signed [35:0] MAX_IDX  = 36'(GRID_RES - 1);
   localparam logic [24:0] CELLS_W         = 25'(CELLS);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_READ, S_READ_WAIT,
      S_BOX_MIN_HI, S_BOX_MIN_LO, S_BOX_MAX_HI, S_BOX_MAX_LO, S_BOX_END,
      S_VX, S_VY, S_VZ, S_VDZ, S_SQY, S_SQZ, S_SUM, S_ROOT, S_UPDATE, S_DONE
   } state_type;

   // point minus centre along one axis: bit 32 flags |delta| >= 2^32
   function automatic logic [32:0] abs_delta(input logic signed [31:0] o,
                                             input logic [39:0] p,
                                             input logic signed [31:0] c);
      logic signed [41:0] d;
      logic [41:0]        a;
      d = $signed({{10{o[31]}}, o}) + $signed({2'b00, p})
          - $signed({{10{c[31]}}, c});
      a = d[41] ? 42'(-d) : d;
      return {(a[41:32] != 10'd0), a[31:0]};
   endfunction

   // configuration
   logic signed [31:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic [30:0]        voxel_step_ff, inverse_step_ff;

   // current word
   logic signed [31:0] cx_ff, cy_ff, cz_ff;
   logic [30:0]        radius_ff;
   logic [17:0]        index_ff;

   state_type          state_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_value_ff;
   logic               oor_ff;
   logic [ADDR_W-1:0]  clr_cnt_ff;

   // bounding box
   logic [1:0]           axis_ff;
   logic signed [67:0]   acc_ff;
   logic signed [35:0]   box_lo_wide_ff;
   logic [IDX_W-1:0]     box_lo_ff [3];
   logic [IDX_W-1:0]     box_hi_ff [3];
   logic                 empty_ff;

   // voxel walk
   logic [IDX_W-1:0]     vi_ff, vj_ff, vk_ff;
   logic [31:0]          ax_ff [3];
   logic                 big_ff;
   logic [65:0]          sum_ff;
   logic                 far_ff;

   // root unit, one result bit a cycle
   logic [63:0]          rad_ff;
   logic [33:0]          rem_ff;
   logic [31:0]          root_ff;
   logic [4:0]           root_cnt_ff;

   // shared multiplier
   logic signed [32:0]   mul_a, mul_b;
   logic signed [65:0]   prod_ff;

   // grid memory
   logic signed [31:0]   grid_mem [CELLS];
   logic signed [31:0]   mem_rdata_ff;
   logic                 mem_we, mem_re;
   logic [ADDR_W-1:0]    mem_waddr, mem_raddr, vox_addr;
   logic signed [31:0]   mem_wdata;

   // combinational helpers
   logic signed [31:0]   c_axis, o_axis;
   logic signed [34:0]   d_min, d_max;
   logic signed [67:0]   acc_sum;
   logic signed [35:0]   b_wide, lo_clamp, hi_clamp;
   logic [32:0]          delta_res;
   logic [65:0]          sum_total;
   logic [35:0]          rem_t, trial;
   logic                 root_ge;
   logic [33:0]          rem_in;
   logic [31:0]          root_in;
   logic signed [33:0]   dist_wide;
   logic signed [31:0]   dist_in;
   logic [24:0]          index_wide;
   logic                 accept;

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_distance_value = rsp_value_ff;
   assign accept             = req_valid && req_ready;
   assign index_wide         = {7'd0, index_ff};

   assign vox_addr = ADDR_W'(vi_ff) * PLANE + ADDR_W'(vj_ff) * ROW + ADDR_W'(vk_ff);

   // axis select for the box
   always_comb begin
      case (axis_ff)
         2'd0:    begin c_axis = cx_ff; o_axis = origin_x_ff; end
         2'd1:    begin c_axis = cy_ff; o_axis = origin_y_ff; end
         default: begin c_axis = cz_ff; o_axis = origin_z_ff; end
      endcase
      d_min = $signed({{3{c_axis[31]}}, c_axis}) - $signed({4'd0, radius_ff})
              - $signed({{3{o_axis[31]}}, o_axis});
      d_max = $signed({{3{c_axis[31]}}, c_axis}) + $signed({4'd0, radius_ff})
              - $signed({{3{o_axis[31]}}, o_axis});
   end

   // multiplier operands per step
   always_comb begin
      mul_a = '0;
      mul_b = $signed({2'b00, inverse_step_ff});
      case (state_ff)
         S_BOX_MIN_HI: mul_a = $signed({{14{d_min[34]}}, d_min[34:16]});
         S_BOX_MIN_LO: mul_a = $signed({17'd0, d_min[15:0]});
         S_BOX_MAX_HI: mul_a = $signed({{14{d_max[34]}}, d_max[34:16]});
         S_BOX_MAX_LO: mul_a = $signed({17'd0, d_max[15:0]});
         S_VX: begin
            mul_a = $signed(33'(vi_ff));
            mul_b = $signed({2'b00, voxel_step_ff});
         end
         S_VY: begin
            mul_a = $signed(33'(vj_ff));
            mul_b = $signed({2'b00, voxel_step_ff});
         end
         S_VZ: begin
            mul_a = $signed(33'(vk_ff));
            mul_b = $signed({2'b00, voxel_step_ff});
         end
         S_VDZ: begin
            mul_a = $signed({1'b0, ax_ff[0]});
            mul_b = $signed({1'b0, ax_ff[0]});
         end
         S_SQY: begin
            mul_a = $signed({1'b0, ax_ff[1]});
            mul_b = $signed({1'b0, ax_ff[1]});
         end
         S_SQZ: begin
            mul_a = $signed({1'b0, ax_ff[2]});
            mul_b = $signed({1'b0, ax_ff[2]});
         end
         default: mul_a = '0;
      endcase
   end

   // box arithmetic, delta, root step and update value
   always_comb begin
      acc_sum  = acc_ff + $signed({{2{prod_ff[65]}}, prod_ff});
      b_wide   = acc_sum[67:32];
      lo_clamp = box_lo_wide_ff[35] ? 36'sd0 : box_lo_wide_ff;
      hi_clamp = (b_wide > MAX_IDX) ? MAX_IDX : b_wide;

      case (state_ff)
         S_VY:    delta_res = abs_delta(origin_x_ff, prod_ff[39:0], cx_ff);
         S_VZ:    delta_res = abs_delta(origin_y_ff, prod_ff[39:0], cy_ff);
         default: delta_res = abs_delta(origin_z_ff, prod_ff[39:0], cz_ff);
      endcase

      sum_total = sum_ff + prod_ff[65:0];

      rem_t   = {rem_ff, rad_ff[63:62]};
      trial   = {2'b00, root_ff, 2'b01};
      root_ge = (rem_t >= trial);
      rem_in  = root_ge ? 34'(rem_t - trial) : rem_t[33:0];
      root_in = {root_ff[30:0], root_ge};

      dist_wide = $signed({2'b00, root_ff}) - $signed({3'b000, radius_ff});
      if (far_ff || dist_wide > 34'sd2147483647) begin
         dist_in = FAR_VALUE;
      end else begin
         dist_in = dist_wide[31:0];
      end
   end

   // memory port control
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = vox_addr;
      mem_wdata = dist_in;
      mem_re    = 1'b0;
      mem_raddr = vox_addr;
      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_ff;
            mem_wdata = FAR_VALUE;
         end
         S_READ: begin
            mem_re    = (index_wide < CELLS_W);
            mem_raddr = index_wide[ADDR_W-1:0];
         end
         S_SQZ:    mem_re = 1'b1;
         S_UPDATE: mem_we = (dist_in < mem_rdata_ff);
         default:  mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= grid_mem[mem_raddr];
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (reset) begin
         state_ff        <= S_CLEAR;
         clr_cnt_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
         origin_x_ff     <= '0;
         origin_y_ff     <= '0;
         origin_z_ff     <= '0;
         voxel_step_ff   <= STEP_RESET;
         inverse_step_ff <= STEP_RESET;
         axis_ff         <= '0;
         empty_ff        <= 1'b0;
         root_cnt_ff     <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ORIGIN_X:     origin_x_ff     <= csr_wdata;
               CSR_ORIGIN_Y:     origin_y_ff     <= csr_wdata;
               CSR_ORIGIN_Z:     origin_z_ff     <= csr_wdata;
               CSR_VOXEL_STEP:   voxel_step_ff   <= csr_wdata[30:0];
               CSR_INVERSE_STEP: inverse_step_ff <= csr_wdata[30:0];
               default:          ;
            endcase
         end

         // a word landing in the read wait state takes over the output register
         if (rsp_valid_ff && rsp_ready && (state_ff != S_READ_WAIT)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == LAST_CELL) begin
                  state_ff <= S_IDLE;
               end
            end

            S_IDLE: begin
               if (accept) begin
                  cx_ff     <= req_center_x;
                  cy_ff     <= req_center_y;
                  cz_ff     <= req_center_z;
                  radius_ff <= req_sphere_radius;
                  index_ff  <= req_voxel_index;
                  case (req_command)
                     CMD_SPLAT: begin
                        axis_ff  <= '0;
                        empty_ff <= 1'b0;
                        state_ff <= S_BOX_MIN_HI;
                     end
                     CMD_READ:  state_ff <= S_READ;
                     CMD_CLEAR: begin
                        clr_cnt_ff <= '0;
                        state_ff   <= S_CLEAR;
                     end
                     default:   state_ff <= S_DONE;
                  endcase
               end
            end

            S_READ: begin
               oor_ff   <= !(index_wide < CELLS_W);
               state_ff <= S_READ_WAIT;
            end

            S_READ_WAIT: begin
               // the output register must be free before the word lands
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_value_ff <= oor_ff ? FAR_VALUE : mem_rdata_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end

            // floor of (c - r - o) * inverse_step / 2^32, split at bit 16
            S_BOX_MIN_HI: state_ff <= S_BOX_MIN_LO;
            S_BOX_MIN_LO: begin
               acc_ff   <= $signed({{2{prod_ff[65]}}, prod_ff}) <<< 16;
               state_ff <= S_BOX_MAX_HI;
            end
            S_BOX_MAX_HI: begin
               box_lo_wide_ff <= acc_sum[67:32];
               state_ff       <= S_BOX_MAX_LO;
            end
            // ceiling of (c + r - o) * inverse_step / 2^32
            S_BOX_MAX_LO: begin
               acc_ff   <= ($signed({{2{prod_ff[65]}}, prod_ff}) <<< 16)
                           + 68'sh0_FFFF_FFFF;
               state_ff <= S_BOX_END;
            end
            S_BOX_END: begin
               box_lo_ff[axis_ff] <= lo_clamp[IDX_W-1:0];
               box_hi_ff[axis_ff] <= hi_clamp[IDX_W-1:0];
               if (axis_ff == 2'd2) begin
                  if (empty_ff || lo_clamp > hi_clamp) begin
                     state_ff <= S_DONE;
                  end else begin
                     vi_ff    <= box_lo_ff[0];
                     vj_ff    <= box_lo_ff[1];
                     vk_ff    <= lo_clamp[IDX_W-1:0];
                     state_ff <= S_VX;
                  end
               end else begin
                  empty_ff <= empty_ff || (lo_clamp > hi_clamp);
                  axis_ff  <= axis_ff + 1'b1;
                  state_ff <= S_BOX_MIN_HI;
               end
            end

            // voxel point offsets, then squared deltas
            S_VX: state_ff <= S_VY;
            S_VY: begin
               ax_ff[0] <= delta_res[31:0];
               big_ff   <= delta_res[32];
               state_ff <= S_VZ;
            end
            S_VZ: begin
               ax_ff[1] <= delta_res[31:0];
               big_ff   <= big_ff || delta_res[32];
               state_ff <= S_VDZ;
            end
            S_VDZ: begin
               ax_ff[2] <= delta_res[31:0];
               big_ff   <= big_ff || delta_res[32];
               state_ff <= S_SQY;
            end
            S_SQY: begin
               sum_ff   <= prod_ff[65:0];
               state_ff <= S_SQZ;
            end
            S_SQZ: begin
               sum_ff   <= sum_total;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               // sum past 64 bits saturates like a huge delta
               far_ff      <= big_ff || (sum_total[65:64] != 2'b00);
               rad_ff      <= sum_total[63:0];
               rem_ff      <= '0;
               root_ff     <= '0;
               root_cnt_ff <= '0;
               state_ff    <= S_ROOT;
            end
            S_ROOT: begin
               rem_ff      <= rem_in;
               root_ff     <= root_in;
               rad_ff      <= {rad_ff[61:0], 2'b00};
               root_cnt_ff <= root_cnt_ff + 1'b1;
               if (root_cnt_ff == 5'd31) begin
                  state_ff <= S_UPDATE;
               end
            end
            S_UPDATE: begin
               // z fastest, then y, then x
               state_ff <= S_VX;
               if (vk_ff != box_hi_ff[2]) begin
                  vk_ff <= vk_ff + 1'b1;
               end else begin
                  vk_ff <= box_lo_ff[2];
                  if (vj_ff != box_hi_ff[1]) begin
                     vj_ff <= vj_ff + 1'b1;
                  end else begin
                     vj_ff <= box_lo_ff[1];
                     if (vi_ff != box_hi_ff[0]) begin
                        vi_ff <= vi_ff + 1'b1;
                     end else begin
                        state_ff <= S_DONE;
                     end
                  end
               end
            end

            S_DONE:  state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// File: rtl/core/sdfs_checker.sv
// port checker for the distance field splatter, bound to the top level
// depends on sdfs_pkg and sphere_distance_field_splat_macros.svh
`timescale 1ns / 1ps
`include "sphere_distance_field_splat_macros.svh"

module sdfs_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input sdfs_pkg::cmd_type   req_command,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic signed [31:0]  rsp_distance_value
);
   import sdfs_pkg::*;

   // a stalled result holds its word
   `SDFS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance_value))

   // the grid sweep after reset keeps the input closed
   `SDFS_ASSERT_ALWAYS(a_reset_busy, reset |=> !req_ready)

   // one word at a time
   `SDFS_ASSERT(a_busy_after_take, req_valid && req_ready |=> !req_ready)

   // only a read makes a result
   `SDFS_ASSERT(a_no_spurious_rsp, req_valid && req_ready && req_command != CMD_READ && !rsp_valid |=> !rsp_valid)

endmodule

bind sphere_distance_field_splat sdfs_checker u_sdfs_checker (.*);

// File: bench/sdfs_scoreboard.sv
// distance field checker: tracks the voxel grid, predicts read words and compares them
// depends on sdfs_pkg; instantiated next to the block by tb_sphere_distance_field_splat
`timescale 1ns / 1ps

module sdfs_scoreboard #(
   parameter int GRID_RES = sdfs_pkg::GRID_RES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  sdfs_pkg::cmd_type       req_command,
   input  logic signed [31:0]      req_center_x,
   input  logic signed [31:0]      req_center_y,
   input  logic signed [31:0]      req_center_z,
   input  logic [30:0]             req_sphere_radius,
   input  logic [17:0]             req_voxel_index,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic signed [31:0]      rsp_distance_value,
   input  logic                    csr_write_enable,
   input  sdfs_pkg::csr_index_type csr_index,
   input  logic [31:0]             csr_wdata,
   output int                      error_count,
   output int                      pending_reads,
   output int                      reads_checked
);
   import sdfs_pkg::*;

   localparam int CELLS = GRID_RES * GRID_RES * GRID_RES;

   logic signed [31:0] distance_grid [CELLS];
   logic signed [31:0] org_x, org_y, org_z;
   logic [30:0]        step, inv_step;
   logic signed [31:0] expected_distances [$];

   initial begin
      error_count = 0;
      pending_reads = 0;
      reads_checked = 0;
   end

   function automatic void fill_far();
      for (int n = 0; n < CELLS; n++) distance_grid[n] = FAR_VALUE;
   endfunction

   // floor of the low corner and ceiling of the high corner, clamped to the grid
   function automatic void axis_bounds(input logic signed [31:0] c, input logic [30:0] r,
                                       input logic signed [31:0] o, output int lo,
                                       output int hi);
      logic signed [95:0] cw, rw, ow, iw, pmin, pmax, a, b;
      cw = 96'(c);
      ow = 96'(o);
      rw = {65'd0, r};
      iw = {65'd0, inv_step};
      pmin = (cw - rw - ow) * iw;
      pmax = (cw + rw - ow) * iw;
      a = pmin >>> 32;
      b = -((-pmax) >>> 32);
      lo = (a < 0) ? 0 : (a > GRID_RES) ? GRID_RES : int'(a);
      hi = (b > GRID_RES - 1) ? GRID_RES - 1 : (b < -1) ? -1 : int'(b);
   endfunction

   function automatic logic signed [31:0] voxel_distance(input logic signed [95:0] dx,
      input logic signed [95:0] dy, input logic signed [95:0] dz, input logic [30:0] r);
      logic [95:0] ax, ay, az, sum, root, trial;
      logic signed [95:0] d;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      az = (dz < 0) ? -dz : dz;
      // any delta of 65536.0 or more saturates
      if (ax >= 96'h1_0000_0000 || ay >= 96'h1_0000_0000 || az >= 96'h1_0000_0000)
         return FAR_VALUE;
      sum = ax * ax + ay * ay + az * az;
      if (sum >= 96'h1_0000_0000_0000_0000) return FAR_VALUE;
      root = '0;
      for (int pos = 31; pos >= 0; pos--) begin
         trial = root | (96'd1 << pos);
         if (trial * trial <= sum) root = trial;
      end
      d = $signed(root) - $signed({65'd0, r});
      if (d > 96'sh7FFF_FFFF) return FAR_VALUE;
      return d[31:0];
   endfunction

   function automatic void apply_splat(input logic signed [31:0] cx,
      input logic signed [31:0] cy, input logic signed [31:0] cz, input logic [30:0] r);
      int i0, i1, j0, j1, k0, k1, at;
      logic signed [95:0] sw, px, py, pz;
      logic signed [31:0] vox_dist;
      axis_bounds(cx, r, org_x, i0, i1);
      axis_bounds(cy, r, org_y, j0, j1);
      axis_bounds(cz, r, org_z, k0, k1);
      if (i0 > i1 || j0 > j1 || k0 > k1) return;
      sw = {65'd0, step};
      for (int i = i0; i <= i1; i++) begin
         px = 96'(org_x);
         px = px + 96'(i) * sw;
         for (int j = j0; j <= j1; j++) begin
            py = 96'(org_y);
            py = py + 96'(j) * sw;
            for (int k = k0; k <= k1; k++) begin
               pz = 96'(org_z);
               pz = pz + 96'(k) * sw;
               at = (i * GRID_RES + j) * GRID_RES + k;
               vox_dist = voxel_distance(px - 96'(cx), py - 96'(cy), pz - 96'(cz), r);
               if (vox_dist < distance_grid[at]) distance_grid[at] = vox_dist;
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         org_x = '0;
         org_y = '0;
         org_z = '0;
         step = STEP_RESET;
         inv_step = STEP_RESET;
         fill_far();
         expected_distances.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ORIGIN_X:     org_x = csr_wdata;
               CSR_ORIGIN_Y:     org_y = csr_wdata;
               CSR_ORIGIN_Z:     org_z = csr_wdata;
               CSR_VOXEL_STEP:   step = csr_wdata[30:0];
               CSR_INVERSE_STEP: inv_step = csr_wdata[30:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_distances.size() == 0) begin
               $error("distance_value: unexpected word, actual %0d", rsp_distance_value);
               error_count++;
            end else begin
               if (rsp_distance_value !== expected_distances[0]) begin
                  $error("distance_value: expected %0d, actual %0d",
                         expected_distances[0], rsp_distance_value);
                  error_count++;
               end
               void'(expected_distances.pop_front());
               reads_checked++;
            end
         end
         if (req_valid && req_ready) begin
            case (req_command)
               CMD_SPLAT: apply_splat(req_center_x, req_center_y, req_center_z,
                                      req_sphere_radius);
               // an index past the grid reads as the far value
               CMD_READ:  expected_distances = {expected_distances,
                             (int'(req_voxel_index) < CELLS) ?
                             distance_grid[req_voxel_index] : FAR_VALUE};
               CMD_CLEAR: fill_far();
               default: ;
            endcase
         end
      end
      pending_reads = expected_distances.size();
   end

endmodule

// File: bench/tb_sphere_distance_field_splat.sv
// top of the distance field splatter bench: clock, reset, stimulus and verdict
// depends on sdfs_pkg, sphere_distance_field_splat and sdfs_scoreboard
`timescale 1ns / 1ps

module tb_sphere_distance_field_splat;
   import sdfs_pkg::*;

   localparam int GRID_RES = GRID_RES_DEF;
   localparam int PHASE_WORDS = 300;
   // a clear, the reset sweep and a splat over a wide box are long quiet stretches
   localparam int WATCHDOG_LIMIT = 2000000;
   localparam int ONE = 65536;
   // index with no register behind it, written as noise
   localparam csr_index_type CSR_UNUSED = 3'd5;
   localparam cmd_type CMD_NONE = 2'd3;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   cmd_type            req_command = CMD_SPLAT;
   logic signed [31:0] req_center_x = '0;
   logic signed [31:0] req_center_y = '0;
   logic signed [31:0] req_center_z = '0;
   logic [30:0]        req_sphere_radius = '0;
   logic [17:0]        req_voxel_index = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_distance_value;
   logic               csr_write_enable = 1'b0;
   csr_index_type      csr_index = CSR_ORIGIN_X;
   logic [31:0]        csr_wdata = '0;

   int error_count, pending_reads, reads_checked;
   int send_idle = 35;
   int recv_idle = 62;
   int words_sent = 0;
   int settings_used = 0;
   int idle_cycles = 0;

   // bench copy of the registers, used only to aim reads at splatted voxels
   logic signed [31:0] cfg_org [3];
   logic [30:0]        cfg_inv;
   logic signed [31:0] last_center [3];

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   sphere_distance_field_splat #(.GRID_RES(GRID_RES)) u_dut (.*);

   sdfs_scoreboard #(.GRID_RES(GRID_RES)) u_scoreboard (.*);

   // receiver stalls at the current rate
   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle);

   // watchdog: ends the run after too long without an accepted request, result or register write
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", idle_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // one request word; returns at the edge where it is taken, valid left high
   task automatic send_word(input cmd_type cmd, input logic signed [31:0] cx,
                            input logic signed [31:0] cy, input logic signed [31:0] cz,
                            input logic [30:0] r, input logic [17:0] idx);
      logic taken;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_center_x <= cx;
      req_center_y <= cy;
      req_center_z <= cz;
      req_sphere_radius <= r;
      req_voxel_index <= idx;
      // ready is stable at the falling edge, so sample it there
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      words_sent++;
      if (cmd == CMD_SPLAT) begin
         last_center[0] = cx;
         last_center[1] = cy;
         last_center[2] = cz;
      end
   endtask

   task automatic read_voxel(input int x, input int y, input int z);
      send_word(CMD_READ, $urandom, $urandom, $urandom, 31'($urandom),
                18'((x * GRID_RES + y) * GRID_RES + z));
   endtask

   // wait until all reads are answered and the block takes words again
   task automatic wait_idle();
      logic quiet;
      req_valid <= 1'b0;
      do begin
         @(negedge clock);
         quiet = (pending_reads == 0) && req_ready;
         @(posedge clock);
      end while (!quiet);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // full register setting, only with the block idle
   task automatic set_config(input logic [31:0] ox, input logic [31:0] oy,
                             input logic [31:0] oz, input logic [31:0] vstep,
                             input logic [31:0] inv);
      wait_idle();
      write_reg(CSR_ORIGIN_X, ox);
      write_reg(CSR_ORIGIN_Y, oy);
      write_reg(CSR_ORIGIN_Z, oz);
      write_reg(CSR_VOXEL_STEP, vstep);
      write_reg(CSR_INVERSE_STEP, inv);
      write_reg(CSR_UNUSED, $urandom);
      csr_write_enable <= 1'b0;
      cfg_org[0] = ox;
      cfg_org[1] = oy;
      cfg_org[2] = oz;
      cfg_inv = inv[30:0];
      settings_used++;
   endtask

   // grid index near a coordinate, jittered by one voxel
   function automatic int near_index(input logic signed [31:0] c, input logic signed [31:0] o);
      logic signed [95:0] t;
      int v;
      t = 96'(c);
      t = ((t - 96'(o)) * $signed({65'd0, cfg_inv})) >>> 32;
      if (t < -2) t = -2;
      if (t > GRID_RES + 1) t = GRID_RES + 1;
      v = int'(t) + int'($urandom_range(2)) - 1;
      return (v < 0) ? 0 : (v > GRID_RES - 1) ? GRID_RES - 1 : v;
   endfunction

   // random splats, reads and unused command words under one register setting
   task automatic random_phase(input int kind);
      logic signed [31:0] c [3];
      logic [30:0] r;
      int pick, done;
      done = 0;
      while (done < PHASE_WORDS) begin
         // idling: sender 35 / receiver 62, then swapped, then none
         if (words_sent < 450) begin
            send_idle = 35;
            recv_idle = 62;
         end else if (words_sent < 900) begin
            send_idle = 62;
            recv_idle = 35;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         pick = $urandom_range(99);
         if (pick < 55) begin
            for (int a = 0; a < 3; a++) begin
               case (kind)
                  0: c[a] = cfg_org[a] + int'($urandom_range(68 * ONE)) - 2 * ONE;
                  1: c[a] = cfg_org[a] + int'($urandom_range(34 * ONE)) - ONE;
                  default: c[a] = $urandom;
               endcase
            end
            case (kind)
               0: r = 31'($urandom_range(3 * ONE / 2));
               1: r = 31'($urandom_range(4 * ONE / 5));
               default: r = 31'($urandom);
            endcase
            send_word(CMD_SPLAT, c[0], c[1], c[2], r, 18'($urandom));
            done++;
         end else if (pick < 95) begin
            if ($urandom_range(9) < 7)
               read_voxel(near_index(last_center[0], cfg_org[0]),
                          near_index(last_center[1], cfg_org[1]),
                          near_index(last_center[2], cfg_org[2]));
            else
               send_word(CMD_READ, $urandom, $urandom, $urandom, 31'($urandom),
                         18'($urandom));
            done++;
         end else begin
            // unused command code, ignored by the block
            send_word(CMD_NONE, $urandom, $urandom, $urandom, 31'($urandom),
                      18'($urandom));
         end
      end
   endtask

   initial begin
      cfg_org = '{0, 0, 0};
      cfg_inv = STEP_RESET;
      last_center = '{0, 0, 0};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed words under the reset setting
      read_voxel(0, 0, 0);
      send_word(CMD_READ, 0, 0, 0, 0, 18'h3FFFF);
      send_word(CMD_NONE, 0, 0, 0, 0, 0);
      send_word(CMD_SPLAT, 0, 0, 0, 0, 0);
      read_voxel(0, 0, 0);
      send_word(CMD_SPLAT, 10 * ONE + ONE / 2, 20 * ONE + ONE / 4, 30 * ONE + 3 * ONE / 4,
                31'(ONE), 0);
      read_voxel(10, 20, 30);
      read_voxel(11, 20, 31);
      // box entirely below the grid, then entirely above it
      send_word(CMD_SPLAT, -100 * ONE, -100 * ONE, -100 * ONE, 31'(ONE), 0);
      send_word(CMD_SPLAT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0);
      read_voxel(GRID_RES - 1, GRID_RES - 1, GRID_RES - 1);
      send_word(CMD_CLEAR, 0, 0, 0, 0, 0);
      read_voxel(0, 0, 0);
      read_voxel(10, 20, 30);

      // extreme registers: widest spacing and tiny reciprocal, deltas saturate
      set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
      send_word(CMD_SPLAT, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                31'h7FFF_FFFF, 0);
      send_word(CMD_SPLAT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0);
      read_voxel(0, 0, 0);
      read_voxel(0, 0, 1);
      read_voxel(0, 1, 0);
      read_voxel(1, 0, 0);
      read_voxel(1, 1, 1);

      // random part, four settings
      set_config($urandom_range(8 * ONE) - 4 * ONE, $urandom_range(8 * ONE) - 4 * ONE,
                 $urandom_range(8 * ONE) - 4 * ONE, ONE, ONE);
      random_phase(0);
      set_config(-32 * ONE, -16 * ONE - ONE / 2, 5 * ONE + ONE / 4, ONE / 2, 2 * ONE);
      send_word(CMD_CLEAR, 0, 0, 0, 0, 0);
      random_phase(1);
      set_config($urandom, $urandom, $urandom, $urandom,
                 {1'($urandom_range(1)), 29'd0, 2'($urandom_range(2))});
      send_word(CMD_CLEAR, 0, 0, 0, 0, 0);
      random_phase(2);
      // zero spacing and zero reciprocal: everything lands on the corner voxel
      set_config($urandom, $urandom, $urandom, 32'h8000_0000, 32'd0);
      random_phase(3);

      wait_idle();
      repeat (100) @(posedge clock);
      $display("run covered %0d request words over %0d register settings",
               words_sent, settings_used + 1);
      $display("%0d read words checked against the predicted grid", reads_checked);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: sphere_distance_field_splat.f
+incdir+rtl/core
rtl/core/sdfs_pkg.sv
rtl/core/sphere_distance_field_splat.sv
rtl/core/sdfs_checker.sv
bench/sdfs_scoreboard.sv
bench/tb_sphere_distance_field_splat.sv
